### hdl/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// Used by modexp_ctrl, modexp_dp and modular_exponentiation; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

   localparam int BASE_W = 64;
   localparam int EXP_W  = 63;
   localparam int MOD_W  = 31;
   localparam int CNT_W  = 6;

   localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

   // Last step of the base reduction (one magnitude bit per cycle)
   localparam logic [CNT_W-1:0] RED_LAST = 6'(BASE_W - 1);
   // Last step of one modular multiply (one multiplier bit per cycle)
   localparam logic [CNT_W-1:0] MUL_LAST = 6'(MOD_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_FIX,
      ST_EBIT,
      ST_MUL,
      ST_COMMIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic red_step;
      logic red_fix;
      logic mul_start;
      logic mul_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic mod_zero;
      logic exp_zero;
   } status_type;

endpackage

`default_nettype wire

### hdl/modexp_ctrl.sv
// Sequencer for the modular exponentiation block: state machine and step counter.
// Depends on modexp_pkg; drives the command struct of modexp_dp.
`timescale 1ns / 1ps
`default_nettype none

module modexp_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   output logic                        rsp_valid,
   input  wire modexp_pkg::status_type status,
   output modexp_pkg::cmd_type         cmd
);

   modexp_pkg::state_type             state_ff, state_in;
   logic [modexp_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                              red_last, mul_last;

   assign red_last = (cnt_ff == modexp_pkg::RED_LAST);
   assign mul_last = (cnt_ff == modexp_pkg::MUL_LAST);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         modexp_pkg::ST_IDLE: begin
            if (start) begin
               state_in = status.mod_zero ? modexp_pkg::ST_DONE : modexp_pkg::ST_REDUCE;
            end
         end
         modexp_pkg::ST_REDUCE: begin
            if (red_last) begin
               state_in = modexp_pkg::ST_FIX;
            end
         end
         modexp_pkg::ST_FIX:    state_in = modexp_pkg::ST_EBIT;
         modexp_pkg::ST_EBIT: begin
            state_in = status.exp_zero ? modexp_pkg::ST_DONE : modexp_pkg::ST_MUL;
         end
         modexp_pkg::ST_MUL: begin
            if (mul_last) begin
               state_in = modexp_pkg::ST_COMMIT;
            end
         end
         modexp_pkg::ST_COMMIT: state_in = modexp_pkg::ST_EBIT;
         modexp_pkg::ST_DONE:   state_in = modexp_pkg::ST_IDLE;
         default:               state_in = modexp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      cnt_in    = '0;
      case (state_ff)
         modexp_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         modexp_pkg::ST_REDUCE: begin
            cmd.red_step = 1'b1;
            cnt_in       = red_last ? '0 : cnt_ff + 1'b1;
         end
         modexp_pkg::ST_FIX:    cmd.red_fix = 1'b1;
         modexp_pkg::ST_EBIT:   cmd.mul_start = !status.exp_zero;
         modexp_pkg::ST_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = mul_last ? '0 : cnt_ff + 1'b1;
         end
         modexp_pkg::ST_COMMIT: cmd.commit = 1'b1;
         modexp_pkg::ST_DONE:   rsp_valid = 1'b1;
         default:               busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= modexp_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

### hdl/modexp_dp.sv
// Datapath for the modular exponentiation block: modulus register, bit-serial
// base reduction and two interleaved modular multiply lanes. Depends on modexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module modexp_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [modexp_pkg::MOD_W-1:0]         csr_wdata,
   input  wire logic signed [modexp_pkg::BASE_W-1:0] req_base,
   input  wire logic [modexp_pkg::EXP_W-1:0]         req_exponent,
   input  wire modexp_pkg::cmd_type                  cmd,
   output modexp_pkg::status_type                    status,
   output logic [modexp_pkg::MOD_W-1:0]              rsp_power
);

   localparam int MW = modexp_pkg::MOD_W;

   logic [MW-1:0]                    mod_ff, mod_in;
   logic [modexp_pkg::BASE_W-1:0]    mag_ff, mag_in;
   logic                             neg_ff, neg_in;
   logic [modexp_pkg::EXP_W-1:0]     exp_ff, exp_in;
   logic [MW-1:0]                    base_ff, base_in;   // also the remainder while reducing
   logic [MW-1:0]                    acc_ff, acc_in;
   logic [MW-1:0]                    sq_ff, sq_in;       // partial base * base
   logic [MW-1:0]                    mp_ff, mp_in;       // partial acc * base
   logic [MW-1:0]                    sa_ff, sa_in;       // multiplier bits, square lane
   logic [MW-1:0]                    ma_ff, ma_in;       // multiplier bits, multiply lane

   logic [MW:0]                      red_t, red_m;

   // One step of an interleaved modular multiply: (2r + add*b) mod m, with r, b < m.
   // The sum is below 3m, so one of three candidates is taken.
   function automatic logic [MW-1:0] dbl_add(input logic [MW-1:0] r, input logic add,
                                             input logic [MW-1:0] b, input logic [MW-1:0] m);
      logic [MW+1:0] t, m1, m2, d1, d2;
      m1 = {2'b00, m};
      m2 = {1'b0, m, 1'b0};
      t  = {1'b0, r, 1'b0} + (add ? {2'b00, b} : '0);
      d1 = t - m1;
      d2 = t - m2;
      if (t >= m2)
         return d2[MW-1:0];
      else if (t >= m1)
         return d1[MW-1:0];
      else
         return t[MW-1:0];
   endfunction

   assign red_t = {base_ff, mag_ff[modexp_pkg::BASE_W-1]};
   assign red_m = {1'b0, mod_ff};

   always_comb begin
      mod_in  = csr_we ? csr_wdata : mod_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      exp_in  = exp_ff;
      base_in = base_ff;
      acc_in  = acc_ff;
      sq_in   = sq_ff;
      mp_in   = mp_ff;
      sa_in   = sa_ff;
      ma_in   = ma_ff;

      if (cmd.load) begin
         neg_in  = req_base[modexp_pkg::BASE_W-1];
         mag_in  = req_base[modexp_pkg::BASE_W-1] ? (~req_base + 1'b1) : req_base;
         exp_in  = req_exponent;
         base_in = '0;
         acc_in  = '0;
      end

      // restoring remainder, one magnitude bit per cycle
      if (cmd.red_step) begin
         base_in = (red_t >= red_m) ? MW'(red_t - red_m) : MW'(red_t);
         mag_in  = {mag_ff[modexp_pkg::BASE_W-2:0], 1'b0};
      end

      if (cmd.red_fix) begin
         if (neg_ff && (base_ff != '0)) begin
            base_in = mod_ff - base_ff;
         end
         acc_in = (mod_ff == MW'(1)) ? '0 : MW'(1);
      end

      if (cmd.mul_start) begin
         sq_in = '0;
         mp_in = '0;
         sa_in = base_ff;
         ma_in = acc_ff;
      end

      if (cmd.mul_step) begin
         sq_in = dbl_add(sq_ff, sa_ff[MW-1], base_ff, mod_ff);
         mp_in = dbl_add(mp_ff, ma_ff[MW-1], base_ff, mod_ff);
         sa_in = {sa_ff[MW-2:0], 1'b0};
         ma_in = {ma_ff[MW-2:0], 1'b0};
      end

      if (cmd.commit) begin
         base_in = sq_ff;
         if (exp_ff[0]) begin
            acc_in = mp_ff;
         end
         exp_in = {1'b0, exp_ff[modexp_pkg::EXP_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= modexp_pkg::MOD_RESET;
      end else begin
         mod_ff <= mod_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      exp_ff  <= exp_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      sq_ff   <= sq_in;
      mp_ff   <= mp_in;
      sa_ff   <= sa_in;
      ma_ff   <= ma_in;
   end

   assign status.mod_zero = (mod_ff == '0);
   assign status.exp_zero = (exp_ff == '0);
   assign rsp_power       = acc_ff;

endmodule

`default_nettype wire

### hdl/modular_exponentiation.sv
// Computes req_base ** req_exponent mod the programmed modulus, right-to-left
// square-and-multiply with a bit-serial modular multiply. Each start word gives one
// rsp_valid strobe of exactly one cycle; the receiver cannot stall it, so it must take
// rsp_power in that cycle. busy is high from the accepted start until the cycle after
// the strobe. The base is first reduced over its 64 magnitude bits, one bit at a time
// (a zero modulus skips straight to the strobe); then each exponent bit takes 31 steps
// of the parallel square and multiply lanes plus the ST_EBIT and ST_COMMIT bookkeeping
// states. The modulus resets to 1000000007; write it through csr_we
// only while busy is low.
// Depends on modexp_pkg, modexp_ctrl and modexp_dp.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic signed [modexp_pkg::BASE_W-1:0] req_base,
   input  wire logic [modexp_pkg::EXP_W-1:0]         req_exponent,
   output logic                                      rsp_valid,
   output logic [modexp_pkg::MOD_W-1:0]              rsp_power,
   input  wire logic                                 csr_we,
   input  wire logic [modexp_pkg::MOD_W-1:0]         csr_wdata
);

   modexp_pkg::cmd_type    cmd;
   modexp_pkg::status_type status;

   modexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   modexp_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .cmd          (cmd),
      .status       (status),
      .rsp_power    (rsp_power)
   );

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for modular_exponentiation: directed corners, then random words.
// The modulus register is swept through several values, including zero, one and the largest.
// Depends on modexp_pkg and the modular_exponentiation RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int REPORT_MAX  = 10;

   typedef struct {
      logic [modexp_pkg::BASE_W-1:0] base;
      logic [modexp_pkg::EXP_W-1:0]  exponent;
      logic [modexp_pkg::MOD_W-1:0]  modulus;
      logic [modexp_pkg::MOD_W-1:0]  power;
   } power_expect_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic signed [modexp_pkg::BASE_W-1:0] req_base;
   logic [modexp_pkg::EXP_W-1:0]         req_exponent;
   logic                                 rsp_valid;
   logic [modexp_pkg::MOD_W-1:0]         rsp_power;
   logic                                 csr_we;
   logic [modexp_pkg::MOD_W-1:0]         csr_wdata;

   power_expect_type             expected_powers[$];
   logic [modexp_pkg::MOD_W-1:0] modulus_shadow;
   int                           mismatch_count;
   int                           burst_left;

   modular_exponentiation u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .rsp_valid    (rsp_valid),
      .rsp_power    (rsp_power),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // base^exponent mod modulus, right-to-left square and multiply
   function automatic logic [modexp_pkg::MOD_W-1:0] predict_power(
         logic [modexp_pkg::BASE_W-1:0] base_raw,
         logic [modexp_pkg::EXP_W-1:0]  exp_raw,
         logic [modexp_pkg::MOD_W-1:0]  mod_val);
      logic [63:0]                  m;
      logic [63:0]                  mag;
      logic [63:0]                  b;
      logic [63:0]                  acc;
      logic [modexp_pkg::EXP_W-1:0] e;
      m = {33'd0, mod_val};
      if (m == 64'd0) return '0;
      // two's complement magnitude; the most negative value maps to 2^63
      mag = base_raw[modexp_pkg::BASE_W-1] ? (~base_raw + 64'd1) : base_raw;
      b = mag % m;
      if (base_raw[modexp_pkg::BASE_W-1] && b != 64'd0) b = m - b;
      acc = 64'd1 % m;
      e = exp_raw;
      while (e != '0) begin
         if (e[0]) acc = (acc * b) % m;
         b = (b * b) % m;
         e = e >> 1;
      end
      return acc[modexp_pkg::MOD_W-1:0];
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // one word through the start/busy handshake; the expectation is queued on acceptance
   task automatic send_word(logic [modexp_pkg::BASE_W-1:0] base,
                            logic [modexp_pkg::EXP_W-1:0] exponent);
      power_expect_type exp_item;
      @(negedge clock);
      start        <= 1'b1;
      req_base     <= base;
      req_exponent <= exponent;
      do @(posedge clock); while (busy);
      exp_item.base     = base;
      exp_item.exponent = exponent;
      exp_item.modulus  = modulus_shadow;
      exp_item.power    = predict_power(base, exponent, modulus_shadow);
      expected_powers.push_back(exp_item);
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (expected_powers.size() != 0 || busy);
   endtask

   task automatic write_modulus(logic [modexp_pkg::MOD_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we         <= 1'b0;
      modulus_shadow = value;
   endtask

   // sender runs in bursts; gaps land anywhere inside the previous word's computation
   task automatic sender_gap();
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 3))
            0:       gap = 0;
            1:       gap = $urandom_range(1, 40);
            2:       gap = $urandom_range(40, 250);
            default: gap = $urandom_range(250, 600);
         endcase
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
   endtask

   function automatic logic [modexp_pkg::BASE_W-1:0] rand_base();
      logic [63:0] m;
      logic [63:0] k;
      m = {33'd0, modulus_shadow};
      k = {32'd0, $urandom} & 64'h0FFF_FFFF;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return rand64();
         5:             return 64'($signed($urandom_range(0, 2000)) - 1000);
         6:             return k * m + 64'($signed($urandom_range(0, 4)) - 2);
         7: begin
            case ($urandom_range(0, 3))
               0:       return 64'h8000_0000_0000_0000;
               1:       return 64'h7FFF_FFFF_FFFF_FFFF;
               2:       return '0;
               default: return '1;
            endcase
         end
         8:             return -(k * m);
         default:       return {{32{1'b0}}, $urandom} ^ ({64{$urandom_range(0, 1) == 1}} << 31);
      endcase
   endfunction

   // mostly short exponents to keep the run time down; some full width
   function automatic logic [modexp_pkg::EXP_W-1:0] rand_exponent();
      int                           len;
      logic [modexp_pkg::EXP_W-1:0] e;
      e = rand64()[modexp_pkg::EXP_W-1:0];
      if ($urandom_range(0, 9) == 0) return e;
      len = $urandom_range(0, 12);
      if (len == 0) return '0;
      return (e & ((63'd1 << len) - 63'd1)) | (63'd1 << (len - 1));
   endfunction

   always @(posedge clock) begin
      power_expect_type exp_item;
      if (!reset && rsp_valid) begin
         if (expected_powers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("ERROR: unexpected word, power %0d", rsp_power);
         end else begin
            exp_item = expected_powers.pop_front();
            if (rsp_power !== exp_item.power) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("ERROR: base %0d exp %0d mod %0d: power expected %0d got %0d",
                           $signed(exp_item.base), exp_item.exponent, exp_item.modulus,
                           exp_item.power, rsp_power);
            end
         end
      end
   end

   // reset value of the modulus, base reduction of signed extremes
   task automatic test_reset_modulus();
      send_word(64'd2, 63'd10);
      send_word(64'd0, 63'd0);
      send_word(64'd0, 63'd5);
      send_word('1, 63'd3);
      send_word(64'h8000_0000_0000_0000, '1);
      send_word(64'h7FFF_FFFF_FFFF_FFFF, 63'd1);
      send_word(-64'(modexp_pkg::MOD_RESET), 63'd5);
      send_word(64'(modexp_pkg::MOD_RESET) - 64'd1, 63'd2);
      send_word(64'd3, '1);
   endtask

   // zero modulus gives 0, modulus one gives 0 even for a zero exponent
   task automatic test_modulus_corners();
      write_modulus('0);
      send_word(64'd7, 63'd0);
      send_word('1, '1);
      write_modulus(31'd1);
      send_word(64'd5, 63'd0);
      send_word(64'h8000_0000_0000_0000, 63'd9);
      write_modulus(31'd2);
      send_word('1, 63'd4);
      send_word(64'd6, 63'd0);
      write_modulus('1);
      send_word('1, '1);
      send_word(64'h7FFF_FFFF_FFFF_FFFF, '1);
      send_word(64'h8000_0000_0000_0000, 63'h2AAA_AAAA_AAAA_AAAA);
   endtask

   task automatic test_random_traffic(logic [modexp_pkg::MOD_W-1:0] mod_val, int count);
      write_modulus(mod_val);
      for (int i = 0; i < count; i++) begin
         sender_gap();
         send_word(rand_base(), rand_exponent());
         if (i == count / 2) wait_idle();
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_base       = '0;
      req_exponent   = '0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      modulus_shadow = modexp_pkg::MOD_RESET;
      mismatch_count = 0;
      burst_left     = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_modulus();
      test_modulus_corners();
      test_random_traffic(31'($urandom) | 31'h4000_0000, 120);
      test_random_traffic(31'($urandom_range(2, 1000)), 100);
      test_random_traffic('1, 100);
      test_random_traffic(modexp_pkg::MOD_RESET, 100);
      test_random_traffic(31'($urandom_range(3, 65535)), 80);

      wait_idle();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_powers.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

endmodule
